>>> design/wpvc_pkg.sv
// wpvc_pkg: shared constants and register codes for the windowed pid velocity command block
// no dependencies; imported by windowed_pid_velocity_command_top
package wpvc_pkg;

	localparam int WINDOW_LEN_DEF = 5;
	localparam int CFG_ADDR_W     = 5;
	localparam int CFG_DATA_W     = 32;

	localparam logic [14:0] SPEED_LIMIT_RST = 15'd512;
	localparam int          YAW_LIMIT       = 2560;
	localparam int          VERT_SHIFT      = 4;
	localparam int          YAW_SHIFT       = 8;

	typedef enum logic [2:0] {
		REG_VERT_KP      = 3'd0,
		REG_VERT_KI      = 3'd1,
		REG_VERT_KD      = 3'd2,
		REG_YAW_KP       = 3'd3,
		REG_YAW_KI       = 3'd4,
		REG_YAW_KD       = 3'd5,
		REG_SPEED_LIMIT  = 3'd6,
		REG_HOLD_HEADING = 3'd7
	} reg_idx_t;

endpackage

>>> design/windowed_pid_velocity_command_top.sv
// windowed_pid_velocity_command_top: windowed pid for vertical and heading channels, velocity clamps
// depends on wpvc_pkg; apb-style register port, valid/stall item channels
//
//   channel  | direction | handshake                    | payload
//   ---------+-----------+------------------------------+-------------------------------------------
//   item     | in        | item_valid / item_stall      | mark_a_vert mark_b_vert heading_error
//            |           |                              | offset_x offset_y ranges_valid
//   result   | out       | result_valid / result_stall  | vel_x vel_y vel_z yaw_cmd heading_setpoint
//   config   | in        | psel penable pwrite pready   | paddr pwdata prdata
//
// one item per cycle sustained while result_stall is low; from accept to result an item passes an
// input register, then the pid datapath (three multiplies per channel and their sum) into the result register
// reset clears the sample windows, the running sums and the previous-sample flag at once
// result_stall holds the result register; item_stall rises only when both stages are full
// and the result is stalled
module windowed_pid_velocity_command_top #(
	parameter int WINDOW_LEN = wpvc_pkg::WINDOW_LEN_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [wpvc_pkg::CFG_ADDR_W-1:0]       paddr,
	input  logic [wpvc_pkg::CFG_DATA_W-1:0]       pwdata,
	output logic [wpvc_pkg::CFG_DATA_W-1:0]       prdata,
	output logic                                  pready,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic signed [15:0]                    mark_a_vert,
	input  logic signed [15:0]                    mark_b_vert,
	input  logic signed [15:0]                    heading_error,
	input  logic signed [15:0]                    offset_x,
	input  logic signed [15:0]                    offset_y,
	input  logic                                  ranges_valid,
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic signed [15:0]                    vel_x,
	output logic signed [15:0]                    vel_y,
	output logic signed [15:0]                    vel_z,
	output logic signed [12:0]                    yaw_cmd,
	output logic signed [12:0]                    heading_setpoint
);
	import wpvc_pkg::*;

	localparam int SUM_W = 16 + $clog2(WINDOW_LEN);
	localparam int ACC_W = 16 + SUM_W + 2;

	// configuration registers
	logic signed [15:0] vert_kp_q, vert_ki_q, vert_kd_q;
	logic signed [15:0] yaw_kp_q, yaw_ki_q, yaw_kd_q;
	logic        [14:0] speed_limit_q;
	logic signed [12:0] hold_heading_q;

	reg_idx_t cfg_idx;
	logic     cfg_wr;

	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_kp_q      <= '0;
			vert_ki_q      <= '0;
			vert_kd_q      <= '0;
			yaw_kp_q       <= '0;
			yaw_ki_q       <= '0;
			yaw_kd_q       <= '0;
			speed_limit_q  <= SPEED_LIMIT_RST;
			hold_heading_q <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_VERT_KP:      vert_kp_q      <= pwdata[15:0];
				REG_VERT_KI:      vert_ki_q      <= pwdata[15:0];
				REG_VERT_KD:      vert_kd_q      <= pwdata[15:0];
				REG_YAW_KP:       yaw_kp_q       <= pwdata[15:0];
				REG_YAW_KI:       yaw_ki_q       <= pwdata[15:0];
				REG_YAW_KD:       yaw_kd_q       <= pwdata[15:0];
				REG_SPEED_LIMIT:  speed_limit_q  <= pwdata[14:0];
				REG_HOLD_HEADING: hold_heading_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_VERT_KP:      prdata = {{16{vert_kp_q[15]}}, vert_kp_q};
			REG_VERT_KI:      prdata = {{16{vert_ki_q[15]}}, vert_ki_q};
			REG_VERT_KD:      prdata = {{16{vert_kd_q[15]}}, vert_kd_q};
			REG_YAW_KP:       prdata = {{16{yaw_kp_q[15]}}, yaw_kp_q};
			REG_YAW_KI:       prdata = {{16{yaw_ki_q[15]}}, yaw_ki_q};
			REG_YAW_KD:       prdata = {{16{yaw_kd_q[15]}}, yaw_kd_q};
			REG_SPEED_LIMIT:  prdata = {17'd0, speed_limit_q};
			REG_HOLD_HEADING: prdata = {{19{hold_heading_q[12]}}, hold_heading_q};
			default:          prdata = '0;
		endcase
	end

	// pipeline control
	logic valid_s1, valid_s2, advance, fire_s1;

	assign advance    = !valid_s2 || !result_stall;
	assign fire_s1    = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!item_stall)
				valid_s1 <= item_valid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	// input register
	logic signed [15:0] mark_a_s1, mark_b_s1, heading_s1, offset_x_s1, offset_y_s1;
	logic               ranges_valid_s1;

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			mark_a_s1       <= mark_a_vert;
			mark_b_s1       <= mark_b_vert;
			heading_s1      <= heading_error;
			offset_x_s1     <= offset_x;
			offset_y_s1     <= offset_y;
			ranges_valid_s1 <= ranges_valid;
		end
	end

	// sample windows with running sums
	logic signed [15:0]      vwin_q [WINDOW_LEN];
	logic signed [15:0]      ywin_q [WINDOW_LEN];
	logic signed [SUM_W-1:0] vsum_q, ysum_q;
	logic                    have_prev_q;

	logic signed [16:0]      ab_sum, zd, yd;
	logic signed [15:0]      zm;
	logic signed [SUM_W-1:0] vsum_new, ysum_new;

	always_comb begin
		ab_sum   = {mark_a_s1[15], mark_a_s1} + {mark_b_s1[15], mark_b_s1};
		zm       = ab_sum[16:1];
		vsum_new = vsum_q + SUM_W'(zm) - SUM_W'(vwin_q[WINDOW_LEN-1]);
		ysum_new = ysum_q + SUM_W'(heading_s1) - SUM_W'(ywin_q[WINDOW_LEN-1]);
		zd       = have_prev_q ? ({zm[15], zm} - {vwin_q[0][15], vwin_q[0]}) : 17'sd0;
		yd       = have_prev_q ? ({heading_s1[15], heading_s1} - {ywin_q[0][15], ywin_q[0]})
		                       : 17'sd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LEN; i++) begin
				vwin_q[i] <= '0;
				ywin_q[i] <= '0;
			end
			vsum_q      <= '0;
			ysum_q      <= '0;
			have_prev_q <= 1'b0;
		end else if (fire_s1) begin
			for (int i = WINDOW_LEN - 1; i > 0; i--) begin
				vwin_q[i] <= vwin_q[i-1];
				ywin_q[i] <= ywin_q[i-1];
			end
			vwin_q[0]   <= zm;
			ywin_q[0]   <= heading_s1;
			vsum_q      <= vsum_new;
			ysum_q      <= ysum_new;
			have_prev_q <= 1'b1;
		end
	end

	// pid datapath
	logic signed [31:0]         vp_prod, yp_prod;
	logic signed [16+SUM_W-1:0] vi_prod, yi_prod;
	logic signed [32:0]         vd_prod, yd_prod;
	logic signed [ACC_W-1:0]    vacc, yacc, vsh, ysh, lim, yaw_lim;
	logic signed [15:0]         vz_c, vx_c, vy_c;
	logic signed [12:0]         yc_c;
	logic signed [16:0]         lim17;

	always_comb begin
		vp_prod = vert_kp_q * zm;
		vi_prod = vert_ki_q * vsum_new;
		vd_prod = vert_kd_q * zd;
		yp_prod = yaw_kp_q * heading_s1;
		yi_prod = yaw_ki_q * ysum_new;
		yd_prod = yaw_kd_q * yd;

		vacc = ACC_W'(vp_prod) + ACC_W'(vi_prod) + ACC_W'(vd_prod);
		yacc = ACC_W'(yp_prod) + ACC_W'(yi_prod) + ACC_W'(yd_prod);
		vsh  = vacc >>> VERT_SHIFT;
		ysh  = yacc >>> YAW_SHIFT;

		lim     = ACC_W'($signed({1'b0, speed_limit_q}));
		yaw_lim = ACC_W'(YAW_LIMIT);

		if (!ranges_valid_s1)
			vz_c = '0;
		else if (vsh > lim)
			vz_c = lim[15:0];
		else if (vsh < -lim)
			vz_c = 16'(-lim);
		else
			vz_c = vsh[15:0];

		if (ysh > yaw_lim)
			yc_c = yaw_lim[12:0];
		else if (ysh < -yaw_lim)
			yc_c = 13'(-yaw_lim);
		else
			yc_c = ysh[12:0];

		lim17 = $signed({2'b00, speed_limit_q});
		if ($signed({offset_x_s1[15], offset_x_s1}) > lim17)
			vx_c = lim17[15:0];
		else if ($signed({offset_x_s1[15], offset_x_s1}) < -lim17)
			vx_c = 16'(-lim17);
		else
			vx_c = offset_x_s1;

		if ($signed({offset_y_s1[15], offset_y_s1}) > lim17)
			vy_c = lim17[15:0];
		else if ($signed({offset_y_s1[15], offset_y_s1}) < -lim17)
			vy_c = 16'(-lim17);
		else
			vy_c = offset_y_s1;
	end

	// result register
	logic signed [15:0] vel_x_s2, vel_y_s2, vel_z_s2;
	logic signed [12:0] yaw_cmd_s2, heading_s2;

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			vel_x_s2   <= vx_c;
			vel_y_s2   <= vy_c;
			vel_z_s2   <= vz_c;
			yaw_cmd_s2 <= yc_c;
			heading_s2 <= hold_heading_q;
		end
	end

	assign result_valid     = valid_s2;
	assign vel_x            = vel_x_s2;
	assign vel_y            = vel_y_s2;
	assign vel_z            = vel_z_s2;
	assign yaw_cmd          = yaw_cmd_s2;
	assign heading_setpoint = heading_s2;

	// checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && valid_s2 && result_stall))
		else $error("item stall without a full pipeline");

	a_yaw_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ($signed(yaw_cmd) <= 13'sd2560 && $signed(yaw_cmd) >= -13'sd2560))
		else $error("yaw command outside clamp");

	a_vz_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && !ranges_valid_s1) |=> (vel_z == 16'sd0))
		else $error("vertical command not zero with ranges invalid");

	a_prev_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> have_prev_q)
		else $error("previous-sample flag not set after an item");

endmodule
